>>> rtl/core/logistic_regression_sgd_assert.svh
// Assertion macros for the logistic regression block.
`ifndef LOGISTIC_REGRESSION_SGD_ASSERT_SVH
`define LOGISTIC_REGRESSION_SGD_ASSERT_SVH

// Checked only outside reset.
`define LRSGD_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Checked at every edge, reset included.
`define LRSGD_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/lrsgd_pkg.sv
// Package: types, constants and helpers of the logistic regression block.
`default_nettype none
package lrsgd_pkg;
   localparam int SIGMOID_TABLE_DEPTH_DEF = 256;
   localparam int FEAT_W = 16;
   localparam int WEIGHT_W = 32;
   localparam int NUM_W = 5;
   localparam int CNT_W = 16;
   localparam int LR_W = 16;
   localparam int PROB_W = 16;
   localparam logic [LR_W-1:0] LR_RESET = 16'd12800;

   localparam logic signed [WEIGHT_W-1:0] W0_RESET = 32'sd880;
   localparam logic signed [WEIGHT_W-1:0] W1_RESET = 32'sd2245;
   localparam logic signed [WEIGHT_W-1:0] W2_RESET = -32'sd3678;
   localparam logic signed [WEIGHT_W-1:0] W3_RESET = 32'sd6452;
   localparam logic signed [WEIGHT_W-1:0] W4_RESET = -32'sd60519;

   typedef enum logic [1:0] {
      CMD_TRAIN    = 2'd0,
      CMD_CLASSIFY = 2'd1,
      CMD_CLEAR    = 2'd2,
      CMD_NONE     = 2'd3
   } command_type;

   typedef struct packed {
      logic [1:0]               command;
      logic signed [FEAT_W-1:0] feature_1;
      logic signed [FEAT_W-1:0] feature_2;
      logic signed [FEAT_W-1:0] feature_3;
      logic signed [FEAT_W-1:0] feature_4;
      logic                     label;
   } req_type;

   typedef struct packed {
      logic              predicted_class;
      logic [PROB_W-1:0] probability;
      logic [CNT_W-1:0]  true_positive_count;
      logic [CNT_W-1:0]  false_positive_count;
      logic [CNT_W-1:0]  true_negative_count;
      logic [CNT_W-1:0]  false_negative_count;
   } rsp_type;

   // Shift-subtract divide, used only when building constant tables.
   function automatic longint unsigned udiv(input longint unsigned n, input longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [PROB_W-1:0] sigmoid_entry(input int idx, input int depth);
      longint num;
      longint c;
      longint t;
      longint u;
      longint term;
      longint e;
      longint d;
      longint r;
      num = (2 * longint'(idx) + 1) * (longint'(8) <<< 31);
      c = longint'(udiv(longint'(num), longint'(depth))) - (longint'(8) <<< 31);
      t = (c < 0) ? -c : c;
      u = t >>> 4;
      term = longint'(1) <<< 31;
      e = longint'(1) <<< 31;
      for (int k = 1; k <= 16; k++) begin
         term = longint'(udiv(longint'((term * u) >>> 31), longint'(k)));
         if (k % 2 == 1) e = e - term;
         else e = e + term;
      end
      if (e < 0) e = 0;
      for (int k = 0; k < 4; k++) e = (e * e + (longint'(1) <<< 30)) >>> 31;
      d = (longint'(1) <<< 31) + e;
      if (c >= 0) r = longint'(udiv(longint'((longint'(1) <<< 47) + (d >>> 1)), longint'(d)));
      else r = longint'(udiv(longint'(e * 65536 + (d >>> 1)), longint'(d)));
      if (r > 65535) r = 65535;
      return r[PROB_W-1:0];
   endfunction
endpackage
`default_nettype wire

>>> rtl/core/logistic_regression_sgd.sv
// Logistic regression classifier with fixed-point SGD training, bit-serial datapath.
// Usage:
//  req channel: one item per command (train, classify, clear counters) with four
//    signed Q8.8 features and a label. req_stall is high while an item is in work.
//  rsp channel: one item per request: class, Q0.16 probability from the weights
//    held before the item, and the four confusion counters after it.
//  csr channel: writes the Q8.8 learning rate; always ready, write only when idle.
// Sequence: the dot product runs a shift-add per weight, then table index and
//  lookup and the command decision. Classify, clear and no-op items then load
//  the output. Train first adds rate times error and, per weight, the gradient
//  and saturating update. One item is in work at a time; the next is taken in
//  the cycle after the output is loaded.
// Reset: weights return to their initial values, counters to zero, learning rate
//  to 50.0; no response is pending.
// Stall: a finished response waits in the output register while rsp_stall is
//  high; the next item is accepted meanwhile and waits at its end for the slot.
`default_nettype none
module logistic_regression_sgd #(
   parameter int SIGMOID_TABLE_DEPTH = lrsgd_pkg::SIGMOID_TABLE_DEPTH_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  lrsgd_pkg::req_type       req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output lrsgd_pkg::rsp_type       rsp_data,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire [lrsgd_pkg::LR_W-1:0] csr_data
);
   import lrsgd_pkg::*;

   localparam int DEPTH = SIGMOID_TABLE_DEPTH;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int ACC_W = 52;
   localparam int A_W = 33;
   localparam int B_W = 17;
   localparam int BIT_W = $clog2(B_W);
   localparam int K_W = $clog2(NUM_W);
   localparam int ZOFF_W = 28;
   localparam int PRD_W = ZOFF_W + IDX_W + 1;
   localparam int NW_W = 35;
   localparam int DEL_W = 33;

   typedef logic [PROB_W-1:0] sig_table_type [DEPTH];

   function automatic sig_table_type build_table();
      sig_table_type tbl;
      for (int i = 0; i < DEPTH; i++) tbl[i] = sigmoid_entry(i, DEPTH);
      return tbl;
   endfunction

   localparam sig_table_type SIG_TABLE = build_table();

   typedef enum logic [3:0] {
      S_IDLE, S_DOT, S_INDEX, S_LOOKUP, S_DECIDE, S_RATE, S_GRAD, S_UPDATE, S_DONE
   } state_type;

   state_type                  state_ff;
   logic signed [WEIGHT_W-1:0] weight_ff [NUM_W];
   logic signed [B_W-1:0]      x_ff [NUM_W];
   logic [CNT_W-1:0]           tp_ff, fp_ff, tn_ff, fn_ff;
   logic [LR_W-1:0]            lr_ff;
   logic [1:0]                 cmd_ff;
   logic                       label_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ACC_W-1:0]    a_sh_ff;
   logic signed [B_W-1:0]      b_sh_ff;
   logic [BIT_W-1:0]           bit_ff;
   logic [K_W-1:0]             k_ff, k_next;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [PROB_W-1:0]          p_ff;
   logic signed [A_W-1:0]      m_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_ff;
   logic                       last_bit;
   logic                       pred;
   logic signed [A_W-1:0]      err;
   logic signed [ZOFF_W:0]     zoff;
   logic [PRD_W-1:0]           prd;
   logic [IDX_W:0]             q;
   logic [ACC_W-1:0]           mag;
   logic [DEL_W-1:0]           del_mag;
   logic signed [NW_W-1:0]     nw;
   logic signed [WEIGHT_W-1:0] nw_sat;
   logic                       slot_free;
   logic signed [ACC_W-1:0]    lim;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign last_bit = (bit_ff == BIT_W'(B_W - 1));
   assign k_next = (k_ff == K_W'(NUM_W - 1)) ? '0 : k_ff + K_W'(1);
   assign pred = p_ff[PROB_W-1];
   assign err = A_W'(signed'({1'b0, p_ff})) - (label_ff ? A_W'(65536) : A_W'(0));
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign lim = ACC_W'(1) <<< 27;

   always_comb begin
      acc_in = acc_ff;
      if (b_sh_ff[0]) acc_in = last_bit ? acc_ff - a_sh_ff : acc_ff + a_sh_ff;
   end

   always_comb begin
      zoff = (ZOFF_W + 1)'(acc_ff + lim);
      prd = PRD_W'(unsigned'(zoff[ZOFF_W-1:0])) * PRD_W'(DEPTH);
      q = prd[PRD_W-1:ZOFF_W];
      priority if (acc_ff < -lim) idx_in = '0;
      else if (acc_ff >= lim) idx_in = IDX_W'(DEPTH - 1);
      else if (q >= (IDX_W + 1)'(DEPTH)) idx_in = IDX_W'(DEPTH - 1);
      else idx_in = q[IDX_W-1:0];
   end

   always_comb begin
      mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      del_mag = DEL_W'((mag + ACC_W'(32768)) >> 16);
      nw = NW_W'(weight_ff[k_ff]);
      if (acc_ff[ACC_W-1]) nw = nw + NW_W'(signed'({1'b0, del_mag}));
      else nw = nw - NW_W'(signed'({1'b0, del_mag}));
      priority if (nw > NW_W'(32'sh7FFF_FFFF)) nw_sat = 32'sh7FFF_FFFF;
      else if (nw < -(NW_W'(1) <<< 31)) nw_sat = 32'sh8000_0000;
      else nw_sat = nw[WEIGHT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         weight_ff[0] <= W0_RESET;
         weight_ff[1] <= W1_RESET;
         weight_ff[2] <= W2_RESET;
         weight_ff[3] <= W3_RESET;
         weight_ff[4] <= W4_RESET;
         tp_ff <= '0;
         fp_ff <= '0;
         tn_ff <= '0;
         fn_ff <= '0;
         lr_ff <= LR_RESET;
      end else begin
         if (csr_valid && csr_ready) lr_ff <= csr_data;
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff <= req_data.command;
                  label_ff <= req_data.label;
                  x_ff[0] <= B_W'(256);
                  x_ff[1] <= B_W'(req_data.feature_1);
                  x_ff[2] <= B_W'(req_data.feature_2);
                  x_ff[3] <= B_W'(req_data.feature_3);
                  x_ff[4] <= B_W'(req_data.feature_4);
                  acc_ff <= '0;
                  a_sh_ff <= ACC_W'(weight_ff[0]);
                  b_sh_ff <= B_W'(256);
                  bit_ff <= '0;
                  k_ff <= '0;
                  state_ff <= S_DOT;
               end
            end
            S_DOT: begin
               acc_ff <= acc_in;
               if (last_bit) begin
                  bit_ff <= '0;
                  k_ff <= k_next;
                  a_sh_ff <= ACC_W'(weight_ff[k_next]);
                  b_sh_ff <= x_ff[k_next];
                  if (k_ff == K_W'(NUM_W - 1)) state_ff <= S_INDEX;
               end else begin
                  a_sh_ff <= a_sh_ff <<< 1;
                  b_sh_ff <= b_sh_ff >>> 1;
                  bit_ff <= bit_ff + BIT_W'(1);
               end
            end
            S_INDEX: begin
               idx_ff <= idx_in;
               state_ff <= S_LOOKUP;
            end
            S_LOOKUP: begin
               p_ff <= SIG_TABLE[idx_ff];
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               unique case (cmd_ff)
                  CMD_TRAIN: begin
                     acc_ff <= '0;
                     a_sh_ff <= ACC_W'(err);
                     b_sh_ff <= B_W'({1'b0, lr_ff});
                     bit_ff <= '0;
                     state_ff <= S_RATE;
                  end
                  CMD_CLASSIFY: begin
                     priority if (label_ff && pred) begin
                        if (tp_ff != '1) tp_ff <= tp_ff + CNT_W'(1);
                     end else if (label_ff) begin
                        if (fn_ff != '1) fn_ff <= fn_ff + CNT_W'(1);
                     end else if (pred) begin
                        if (fp_ff != '1) fp_ff <= fp_ff + CNT_W'(1);
                     end else begin
                        if (tn_ff != '1) tn_ff <= tn_ff + CNT_W'(1);
                     end
                     state_ff <= S_DONE;
                  end
                  CMD_CLEAR: begin
                     tp_ff <= '0;
                     fp_ff <= '0;
                     tn_ff <= '0;
                     fn_ff <= '0;
                     state_ff <= S_DONE;
                  end
                  default: state_ff <= S_DONE;
               endcase
            end
            S_RATE: begin
               if (last_bit) begin
                  m_ff <= acc_in[A_W-1:0];
                  acc_ff <= '0;
                  a_sh_ff <= ACC_W'(signed'(acc_in[A_W-1:0]));
                  b_sh_ff <= x_ff[0];
                  bit_ff <= '0;
                  k_ff <= '0;
                  state_ff <= S_GRAD;
               end else begin
                  acc_ff <= acc_in;
                  a_sh_ff <= a_sh_ff <<< 1;
                  b_sh_ff <= b_sh_ff >>> 1;
                  bit_ff <= bit_ff + BIT_W'(1);
               end
            end
            S_GRAD: begin
               acc_ff <= acc_in;
               if (last_bit) begin
                  state_ff <= S_UPDATE;
               end else begin
                  a_sh_ff <= a_sh_ff <<< 1;
                  b_sh_ff <= b_sh_ff >>> 1;
                  bit_ff <= bit_ff + BIT_W'(1);
               end
            end
            S_UPDATE: begin
               weight_ff[k_ff] <= nw_sat;
               acc_ff <= '0;
               a_sh_ff <= ACC_W'(m_ff);
               b_sh_ff <= x_ff[k_next];
               bit_ff <= '0;
               k_ff <= k_next;
               state_ff <= (k_ff == K_W'(NUM_W - 1)) ? S_DONE : S_GRAD;
            end
            S_DONE: begin
               if (slot_free) begin
                  rsp_ff.predicted_class <= pred;
                  rsp_ff.probability <= p_ff;
                  rsp_ff.true_positive_count <= tp_ff;
                  rsp_ff.false_positive_count <= fp_ff;
                  rsp_ff.true_negative_count <= tn_ff;
                  rsp_ff.false_negative_count <= fn_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/lrsgd_checker.sv
// Port-level checker for the logistic regression block, bound to the top level.
`default_nettype none
`include "logistic_regression_sgd_assert.svh"
module lrsgd_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_valid,
   input wire                       req_stall,
   input wire                       rsp_valid,
   input wire                       rsp_stall,
   input lrsgd_pkg::rsp_type        rsp_data
);
   import lrsgd_pkg::*;

   `LRSGD_ASSERT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid && !req_stall, "not idle after reset")
   `LRSGD_ASSERT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "item accepted without going busy")
   `LRSGD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "stalled response dropped")
   `LRSGD_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data), "stalled response changed")
endmodule

bind logistic_regression_sgd lrsgd_checker u_lrsgd_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);
`default_nettype wire

>>> test/tb.sv
// Testbench for logistic_regression_sgd: directed and random items checked against a predictor.
module tb;
   import lrsgd_pkg::*;

   localparam int DEPTH = SIGMOID_TABLE_DEPTH_DEF;

   class lr_scoreboard;
      logic signed [31:0] weight[NUM_W];
      logic [15:0] tally[4];
      logic [15:0] rate;
      logic [15:0] sig_lut[DEPTH];
      rsp_type want_q[$];
      int errors;

      function new();
         longint c, t, u, term, e, d, r;
         for (int i = 0; i < DEPTH; i++) begin
            c = ((2 * longint'(i) + 1) * (longint'(8) << 31)) / DEPTH - (longint'(8) << 31);
            t = c < 0 ? -c : c;
            u = t >>> 4;
            term = longint'(1) << 31;
            e = term;
            for (int k = 1; k <= 16; k++) begin
               term = ((term * u) >>> 31) / k;
               e = (k % 2) ? e - term : e + term;
            end
            if (e < 0) e = 0;
            repeat (4) e = (e * e + (longint'(1) << 30)) >>> 31;
            d = (longint'(1) << 31) + e;
            r = (c >= 0) ? ((longint'(1) << 47) + d / 2) / d : (e * 65536 + d / 2) / d;
            sig_lut[i] = r > 65535 ? 16'hFFFF : r[15:0];
         end
         weight = '{W0_RESET, W1_RESET, W2_RESET, W3_RESET, W4_RESET};
         tally = '{default: '0};
         rate = LR_RESET;
         errors = 0;
      endfunction

      function void note(req_type r);
         longint x[NUM_W], z, lim, idx, err, prod, mag, delta, nw;
         logic [15:0] p;
         logic pred;
         rsp_type o;
         x[0] = 256;
         x[1] = longint'(r.feature_1);
         x[2] = longint'(r.feature_2);
         x[3] = longint'(r.feature_3);
         x[4] = longint'(r.feature_4);
         z = 0;
         for (int k = 0; k < NUM_W; k++) z += longint'(weight[k]) * x[k];
         lim = longint'(8) << 24;
         if (z < -lim) idx = 0;
         else if (z >= lim) idx = DEPTH - 1;
         else idx = ((z + lim) * DEPTH) >>> 28;
         if (idx >= DEPTH) idx = DEPTH - 1;
         p = sig_lut[idx];
         pred = p >= 16'd32768;
         case (command_type'(r.command))
            CMD_TRAIN: begin
               err = longint'(p) - (r.label ? 65536 : 0);
               for (int k = 0; k < NUM_W; k++) begin
                  prod = longint'(rate) * err * x[k];
                  mag = prod < 0 ? -prod : prod;
                  delta = (mag + 32768) >>> 16;
                  if (prod < 0) delta = -delta;
                  nw = longint'(weight[k]) - delta;
                  if (nw > 64'sd2147483647) nw = 64'sd2147483647;
                  if (nw < -64'sd2147483648) nw = -64'sd2147483648;
                  weight[k] = nw[31:0];
               end
            end
            CMD_CLASSIFY: begin
               idx = r.label ? (pred ? 0 : 3) : (pred ? 1 : 2);
               if (tally[idx] != 16'hFFFF) tally[idx]++;
            end
            CMD_CLEAR: tally = '{default: '0};
            default: ;
         endcase
         o.predicted_class = pred;
         o.probability = p;
         o.true_positive_count = tally[0];
         o.false_positive_count = tally[1];
         o.true_negative_count = tally[2];
         o.false_negative_count = tally[3];
         want_q = {want_q, o};
      endfunction

      function void check(rsp_type got);
         rsp_type w;
         if (want_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
         end
         w = want_q.pop_front();
         if (got.predicted_class !== w.predicted_class
               || got.probability !== w.probability
               || got.true_positive_count !== w.true_positive_count
               || got.false_positive_count !== w.false_positive_count
               || got.true_negative_count !== w.true_negative_count
               || got.false_negative_count !== w.false_negative_count) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: class %0d/%0d prob %0d/%0d tp %0d/%0d fp %0d/%0d tn %0d/%0d fn %0d/%0d",
                  w.predicted_class, got.predicted_class, w.probability, got.probability,
                  w.true_positive_count, got.true_positive_count,
                  w.false_positive_count, got.false_positive_count,
                  w.true_negative_count, got.true_negative_count,
                  w.false_negative_count, got.false_negative_count);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [LR_W-1:0] csr_data = '0;

   lr_scoreboard sb = new();
   bit gaps_on = 1;
   int hold_off = 0;

   logistic_regression_sgd i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   initial begin
      int burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_stall = 1;
            hold_off--;
         end else begin
            if (gaps_on && burst == 0 && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 14);
            if (!gaps_on) burst = 0;
            rsp_stall = burst > 0;
            if (burst > 0) burst--;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_data);
   end

   task automatic send(req_type r);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_data = r;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      sb.note(r);
      @(negedge clock);
   endtask

   task automatic set_rate(logic [LR_W-1:0] v);
      req_valid = 0;
      while (sb.want_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_data = v;
      csr_valid = 1;
      do @(posedge clock); while (!csr_ready);
      sb.rate = v;
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic logic [15:0] rand_feature();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 65535);
         1: return 16'($signed($urandom_range(0, 1024)) - 512);
         2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: return 16'($signed($urandom_range(0, 64)) - 32);
      endcase
   endfunction

   function automatic req_type rand_item();
      req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r.command = pick < 40 ? CMD_TRAIN : pick < 88 ? CMD_CLASSIFY : pick < 95 ? CMD_CLEAR : CMD_NONE;
      r.feature_1 = rand_feature();
      r.feature_2 = rand_feature();
      r.feature_3 = rand_feature();
      r.feature_4 = rand_feature();
      r.label = $urandom_range(0, 1);
      return r;
   endfunction

   function automatic req_type item(command_type c, logic [15:0] f1, logic [15:0] f2,
         logic [15:0] f3, logic [15:0] f4, logic lab);
      req_type r;
      r.command = c;
      r.feature_1 = f1;
      r.feature_2 = f2;
      r.feature_3 = f3;
      r.feature_4 = f4;
      r.label = lab;
      return r;
   endfunction

   initial begin
      logic [LR_W-1:0] rates[5];
      rates = '{16'hFFFF, 16'd0, 16'd1, 16'd256, 16'($urandom_range(0, 65535))};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      set_rate(LR_RESET);
      send(item(CMD_CLASSIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
      send(item(CMD_CLASSIFY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
      send(item(CMD_CLASSIFY, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
      send(item(CMD_CLASSIFY, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1));
      send(item(CMD_CLASSIFY, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0));
      send(item(CMD_NONE, 16'h1234, 16'hFEDC, 16'h0100, 16'hFF00, 1'b1));
      send(item(CMD_TRAIN, 16'h0100, 16'h0200, 16'hFF00, 16'h0080, 1'b1));
      send(item(CMD_TRAIN, 16'h0100, 16'h0200, 16'hFF00, 16'h0080, 1'b0));
      send(item(CMD_CLASSIFY, 16'h0100, 16'h0200, 16'hFF00, 16'h0080, 1'b1));
      send(item(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
      send(item(CMD_CLASSIFY, 16'h0010, 16'hFFF0, 16'h0020, 16'hFFE0, 1'b0));
      set_rate(16'hFFFF);
      // drive weights into saturation both ways
      repeat (3) send(item(CMD_TRAIN, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1));
      repeat (3) send(item(CMD_TRAIN, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0));
      send(item(CMD_CLASSIFY, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1));
      send(item(CMD_CLASSIFY, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0));
      send(item(CMD_NONE, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0));

      foreach (rates[i]) begin
         set_rate(rates[i]);
         if (i == 1) hold_off = 600;
         if (i == 4) gaps_on = 0;
         repeat (370) send(rand_item());
      end
      req_valid = 0;

      while (sb.want_q.size() != 0) @(negedge clock);
      repeat (250) @(posedge clock);
      if (sb.errors == 0 && sb.want_q.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #30000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
